/* src/pba_pkg.sv */
package pba_pkg;

  localparam int ADDR_W   = 48;
  localparam int LOG2_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2    = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [LOG2_W-1:0] PAGE_LOG2_RESET = 5'd12;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } pba_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic                region_aligned;
  } pba_out_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } pba_state_t;

endpackage

/* src/pba_ram.sv */
module pba_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/pba_outq.sv */
module pba_outq
  import pba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pba_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_ready,
  output pba_out_t out_data
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  pba_out_t out_r, out_nxt;
  pba_out_t skid_r, skid_nxt;
  logic     pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!out_valid_nxt) begin
        out_nxt       = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/page_bump_and_free_fifo_allocator.sv */
// Page allocator over [region_start, region_end): hands out pages from a queue
// of freed page indices first, then from a bump pointer. A free of the page
// just below the pointer pulls it back; other valid frees go to the queue if
// it has room. Every word in gives exactly one word out, bar a config write
// as a queue allocate is taken. A queue allocate passes through S_READ, as
// the queue RAM has a registered read; other words are pushed out as taken.
// A two-deep output buffer lets the next word in while a result waits. Any
// config register write re-inits the pointer and empties the queue at once.
module page_bump_and_free_fifo_allocator
  import pba_pkg::*;
#(
  parameter int MAX_PAGES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pba_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pba_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);

  logic [ADDR_W-1:0] region_start_r, region_end_r;
  logic [LOG2_W-1:0] page_log2_r;
  logic [ADDR_W-1:0] bump_r, bump_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  pba_state_t        state_r, state_nxt;

  logic              accept;
  logic [ADDR_W-1:0] page_size, low_mask, rs_page, addr;
  logic [ADDR_W:0]   bump_adv, addr_adv;
  logic [ADDR_W-1:0] free_idx, alloc_sum;
  logic              aligned, bad_free, queue_full;
  logic [IDX_W-1:0]  rd_idx;
  logic              ram_we;
  logic              push;
  pba_out_t          push_data;
  logic              outq_full;

  assign page_size = ADDR_W'(1) << page_log2_r;
  assign low_mask  = page_size - ADDR_W'(1);
  assign rs_page   = region_start_r >> page_log2_r;
  assign aligned   = ((region_start_r & low_mask) == '0) && ((region_end_r & low_mask) == '0);
  assign addr      = in_data.address;

  assign bump_adv   = {1'b0, bump_r} + {1'b0, page_size};
  assign addr_adv   = {1'b0, addr} + {1'b0, page_size};
  assign free_idx   = (addr >> page_log2_r) - rs_page;
  assign alloc_sum  = rs_page + ADDR_W'(rd_idx);
  assign bad_free   = ((addr & low_mask) != '0) || (addr < region_start_r)
                      || (addr >= region_end_r);
  assign queue_full = (count_r == CNT_W'(MAX_PAGES));

  assign in_ready = (state_r == S_IDLE) && !outq_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    bump_nxt  = bump_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ram_we    = 1'b0;
    push      = 1'b0;
    push_data.status         = ST_OK;
    push_data.page_address   = '0;
    push_data.region_aligned = aligned;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_ALLOC) begin
            if (count_r != '0) begin
              // data for head_r comes back next cycle
              head_nxt  = (head_r == IDX_W'(MAX_PAGES - 1)) ? '0 : head_r + IDX_W'(1);
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_READ;
            end else if (bump_r < region_end_r) begin
              push                   = 1'b1;
              push_data.page_address = bump_r;
              bump_nxt = bump_adv[ADDR_W] ? '1 : bump_adv[ADDR_W-1:0];
            end else begin
              push             = 1'b1;
              push_data.status = ST_NO_MEM;
            end
          end else begin
            push = 1'b1;
            if (bad_free) begin
              push_data.status = ST_REJECTED;
            end else if (addr_adv == {1'b0, bump_r}) begin
              bump_nxt = bump_r - page_size;
            end else if (queue_full || free_idx >= ADDR_W'(MAX_PAGES)) begin
              push_data.status = ST_REJECTED;
            end else begin
              ram_we    = 1'b1;
              tail_nxt  = (tail_r == IDX_W'(MAX_PAGES - 1)) ? '0 : tail_r + IDX_W'(1);
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
      end
      S_READ: begin
        push                   = 1'b1;
        push_data.page_address = alloc_sum << page_log2_r;
        state_nxt              = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= '0;
      page_log2_r    <= PAGE_LOG2_RESET;
      bump_r         <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      state_r        <= S_IDLE;
    end else if (cfg_we && (cfg_index == CFG_REGION_START || cfg_index == CFG_REGION_END
                            || cfg_index == CFG_PAGE_LOG2)) begin
      unique case (cfg_index)
        CFG_REGION_START: region_start_r <= cfg_data;
        CFG_REGION_END:   region_end_r   <= cfg_data;
        default:          page_log2_r    <= cfg_data[LOG2_W-1:0];
      endcase
      bump_r  <= (cfg_index == CFG_REGION_START) ? cfg_data : region_start_r;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      state_r <= S_IDLE;
    end else begin
      bump_r  <= bump_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      state_r <= state_nxt;
    end
  end

  pba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PAGES)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (free_idx[IDX_W-1:0]),
    .raddr (head_r),
    .rdata (rd_idx)
  );

  pba_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (outq_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAGES))
    else $error("free queue count above capacity");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_IDLE)
    else $error("queue read state held more than one cycle");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(MAX_PAGES)) |-> head_r == tail_r)
    else $error("queue pointers disagree with count");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !outq_full)
    else $error("result pushed into full output buffer");

endmodule
